// ----- design/btmx_pkg.sv -----
// Package for the binary trie max-xor set unit: sizes, opcodes, status codes, states.
// No dependencies.
`default_nettype none
package btmx_pkg;
    localparam int NODE_COUNT = 4096;
    localparam int KEY_BITS   = 32;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int CNT_W      = NODE_W + 1;
    localparam int LVL_W      = $clog2(KEY_BITS);

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [LVL_W-1:0]  lvl_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK,
        S_ALLOC_RD,
        S_ALLOC,
        S_ER_RD,
        S_ER,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

// ----- design/binary_trie_max_xor_set_unit.sv -----
// Top level of the binary trie max-xor set unit: sequencer, node memory, free stack.
// Depends on btmx_pkg.
`default_nettype none
// Keeps a set of 32-bit keys as a binary trie in a 4096-node memory (node 0 is
// "absent"; the root's two links sit in registers). One item is processed at a
// time. Every trie level costs a node memory read state, then a use state. A
// query or a duplicate insert is accepted in S_IDLE, walks all 32 levels and has
// its result loaded in S_OUT. An insert that finds a link missing at level d
// stops walking there and spends a read state and a link state on each of the
// 32-d new nodes. An erase of a stored key walks all 32 levels and then climbs
// back, with a read state and a write state per freed node. A query on an empty
// set, an erase of an absent key, an insert that lacks free nodes and an unused
// opcode finish sooner. The result waits in an output register while the next
// item is accepted; a second result stalls the unit until the first one is taken.
module binary_trie_max_xor_set_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // key[31:0]
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // best_key[31:0]
    output logic [1:0]       m_tuser    // status[1:0]
);
    import btmx_pkg::*;

    logic [2*NODE_W-1:0] mem [NODE_COUNT];
    node_t               fstk [NODE_COUNT];
    node_t               path [KEY_BITS];

    state_t state_reg, state_next;
    op_t    op_reg;
    logic [KEY_BITS-1:0] key_reg, acc_reg;
    lvl_t   lvl_reg;
    node_t  node_reg;
    node_t  root0_reg, root1_reg;
    cnt_t   ftop_reg, fresh_reg;
    logic [2*NODE_W-1:0] rd_reg;
    node_t  fs_rd_reg;
    logic   er_last;
    logic   fresh_par_reg;
    logic [31:0] best_reg;
    status_t st_reg;
    logic   outv_reg;

    // current level's key bit
    logic kb;
    assign kb = key_reg[KEY_BITS-1-lvl_reg];

    // links of current node: root from register, else memory read data
    node_t l0, l1, lsel;
    always_comb
    begin
        if (node_reg == '0)
        begin
            l0 = root0_reg;
            l1 = root1_reg;
        end
        else
        begin
            l0 = rd_reg[NODE_W-1:0];
            l1 = rd_reg[2*NODE_W-1:NODE_W];
        end
        lsel = kb ? l1 : l0;
    end

    logic want, qb;
    node_t qn;
    always_comb
    begin
        want = ~kb;
        qb   = ((want ? l1 : l0) != '0) ? want : kb;
        qn   = qb ? l1 : l0;
    end

    cnt_t need, avail;
    always_comb
    begin
        need  = cnt_t'(KEY_BITS) - cnt_t'(lvl_reg);
        avail = ftop_reg + ((fresh_reg < cnt_t'(NODE_COUNT)) ?
                 (cnt_t'(NODE_COUNT) - fresh_reg) : '0);
    end

    // memory read address and write control
    logic        mem_re, mem_we, fs_we;
    node_t       mem_ra, mem_wa, fs_wa;
    logic [2*NODE_W-1:0] mem_wd;
    node_t       new_node;
    always_comb
    begin
        new_node = (ftop_reg != '0) ? fs_rd_reg : fresh_reg[NODE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_reg <= mem[mem_ra];
        if (fs_we)
            fstk[fs_wa] <= path[lvl_reg];
        fs_rd_reg <= fstk[NODE_W'(ftop_reg - cnt_t'(1))];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WALK && op_reg == OP_ERASE && lsel != '0)
            path[lvl_reg] <= lsel;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (s_tvalid && s_tready)
                begin
                    case (op_t'(s_tuser))
                        OP_INSERT, OP_ERASE, OP_QUERY: state_next = S_WALK_RD;
                        default:                       state_next = S_OUT;
                    endcase
                end
            S_WALK_RD: state_next = S_WALK;
            S_WALK:
                if (op_reg == OP_QUERY)
                begin
                    if (node_reg == '0 && l0 == '0 && l1 == '0)
                        state_next = S_OUT;
                    else if (qn == '0 || lvl_reg == lvl_t'(KEY_BITS-1))
                        state_next = S_OUT;
                    else
                        state_next = S_WALK_RD;
                end
                else if (lsel == '0)
                begin
                    if (op_reg == OP_INSERT && avail >= need)
                        state_next = S_ALLOC_RD;
                    else
                        state_next = S_OUT;
                end
                else if (lvl_reg == lvl_t'(KEY_BITS-1))
                    state_next = (op_reg == OP_ERASE) ? S_ER_RD : S_OUT;
                else
                    state_next = S_WALK_RD;
            S_ALLOC_RD: state_next = S_ALLOC;
            S_ALLOC:
                state_next = (lvl_reg == lvl_t'(KEY_BITS-1)) ? S_OUT : S_ALLOC_RD;
            S_ER_RD: state_next = S_ER;
            S_ER:
                if (lvl_reg == '0 || er_last)
                    state_next = S_OUT;
                else
                    state_next = S_ER_RD;
            S_OUT:
                if (!outv_reg || m_tready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // memory control
    logic   pbit;
    node_t  parent;
    logic [2*NODE_W-1:0] pl_new;
    always_comb
    begin
        mem_re = 1'b0;
        mem_ra = node_reg;
        mem_we = 1'b0;
        mem_wa = node_reg;
        mem_wd = '0;
        fs_we  = 1'b0;
        fs_wa  = ftop_reg[NODE_W-1:0];
        parent = (lvl_reg == '0) ? '0 : path[lvl_reg - lvl_t'(1)];
        pbit   = kb;
        pl_new = rd_reg;
        if (pbit)
            pl_new[2*NODE_W-1:NODE_W] = '0;
        else
            pl_new[NODE_W-1:0] = '0;
        case (state_reg)
            S_WALK_RD: mem_re = 1'b1;
            S_ALLOC_RD: mem_re = 1'b1;
            S_ALLOC:
            begin
                // link parent to the new node; a parent made by this insert has
                // no other child yet, and leaf links are never read
                mem_we = (node_reg != '0);
                mem_wa = node_reg;
                mem_wd = fresh_par_reg ? '0 : rd_reg;
                if (kb)
                    mem_wd[2*NODE_W-1:NODE_W] = new_node;
                else
                    mem_wd[NODE_W-1:0] = new_node;
            end
            S_ER_RD:
            begin
                mem_re = 1'b1;
                mem_ra = parent;
            end
            S_ER:
            begin
                fs_we = (ftop_reg < cnt_t'(NODE_COUNT));
                if (parent != '0)
                begin
                    mem_we = 1'b1;
                    mem_wa = parent;
                    mem_wd = pl_new;
                end
            end
            default: ;
        endcase
    end

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            root0_reg <= '0;
            root1_reg <= '0;
            ftop_reg  <= '0;
            fresh_reg <= cnt_t'(1);
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                    if (s_tvalid && s_tready)
                    begin
                        op_reg        <= op_t'(s_tuser);
                        key_reg       <= s_tdata;
                        lvl_reg       <= '0;
                        node_reg      <= '0;
                        acc_reg       <= '0;
                        best_reg      <= '0;
                        st_reg        <= ST_DONE;
                        fresh_par_reg <= 1'b0;
                    end
                S_WALK:
                    if (op_reg == OP_QUERY)
                    begin
                        if (node_reg == '0 && l0 == '0 && l1 == '0)
                            st_reg <= ST_EMPTY;
                        else
                        begin
                            acc_reg  <= {acc_reg[KEY_BITS-2:0], qb};
                            best_reg <= {acc_reg[KEY_BITS-2:0], qb};
                            node_reg <= qn;
                            lvl_reg  <= lvl_reg + lvl_t'(1);
                        end
                    end
                    else if (lsel == '0)
                    begin
                        if (op_reg == OP_INSERT && avail < need)
                            st_reg <= ST_FULL;
                    end
                    else
                    begin
                        node_reg <= lsel;
                        if (lvl_reg != lvl_t'(KEY_BITS-1))
                            lvl_reg <= lvl_reg + lvl_t'(1);
                    end
                S_ALLOC:
                begin
                    if (node_reg == '0)
                    begin
                        if (kb) root1_reg <= new_node;
                        else    root0_reg <= new_node;
                    end
                    if (ftop_reg != '0)
                        ftop_reg <= ftop_reg - cnt_t'(1);
                    else
                        fresh_reg <= fresh_reg + cnt_t'(1);
                    node_reg      <= new_node;
                    fresh_par_reg <= 1'b1;
                    if (lvl_reg != lvl_t'(KEY_BITS-1))
                        lvl_reg <= lvl_reg + lvl_t'(1);
                end
                S_ER:
                begin
                    if (ftop_reg < cnt_t'(NODE_COUNT))
                        ftop_reg <= ftop_reg + cnt_t'(1);
                    if (parent == '0)
                    begin
                        if (kb) root1_reg <= '0;
                        else    root0_reg <= '0;
                    end
                    if (lvl_reg != '0)
                        lvl_reg <= lvl_reg - lvl_t'(1);
                end
                default: ;
            endcase
            if (state_reg == S_OUT && (!outv_reg || m_tready))
                outv_reg <= 1'b1;
            else if (m_tvalid && m_tready)
                outv_reg <= 1'b0;
        end
    end

    // erase stops when the parent keeps another branch or the freed node hangs off the root
    always_comb
    begin
        if (parent == '0)
            er_last = 1'b1;
        else
            er_last = (pl_new != '0);
    end

    // output register; a result waits here while a new item may enter
    logic [31:0] ob_reg;
    status_t     os_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!outv_reg || m_tready))
        begin
            ob_reg <= (st_reg == ST_DONE && op_reg == OP_QUERY) ? best_reg : '0;
            os_reg <= st_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = outv_reg;
    assign m_tdata  = ob_reg;
    assign m_tuser  = os_reg;
endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Testbench for binary_trie_max_xor_set_unit: directed table, then random items of all four opcodes
// checked against a behavioral trie model. Depends on btmx_pkg and the unit RTL.
`timescale 1ns / 100ps
module tb_top;
    import btmx_pkg::*;

    typedef struct packed {
        logic [31:0] best_key;
        logic [1:0]  status;
    } answer_t;

    typedef struct {
        op_t         op;
        logic [31:0] key;
        logic        has_exp;
        answer_t     exp;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    binary_trie_max_xor_set_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata),   // key[31:0]
        .s_tuser(s_tuser),   // op[1:0]
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata),   // best_key[31:0]
        .m_tuser(m_tuser)    // status[1:0]
    );

    always #5 clk = ~clk;

    // trie model state
    node_t       trie_kids [NODE_COUNT][2];
    node_t       top_kids [2];
    node_t       spare_nodes [NODE_COUNT];
    int unsigned spare_cnt;
    int unsigned next_unused;
    node_t       walk_nodes [KEY_BITS];

    answer_t     pending_answers [$];
    logic        pending_typed [$];
    int          err_count = 0;
    int          idle_cycles = 0;
    bit          hold_sink = 0;
    logic [31:0] key_pool [$];

    function automatic node_t kid_get(node_t n, logic b);
        return (n == 0) ? top_kids[b] : trie_kids[n][b];
    endfunction

    function automatic void kid_set(node_t n, logic b, node_t v);
        if (n == 0) top_kids[b] = v;
        else trie_kids[n][b] = v;
    endfunction

    function automatic node_t grab_node();
        node_t n;
        if (spare_cnt > 0) begin
            spare_cnt--;
            n = spare_nodes[spare_cnt];
        end
        else begin
            n = node_t'(next_unused);
            next_unused++;
        end
        trie_kids[n][0] = '0;
        trie_kids[n][1] = '0;
        return n;
    endfunction

    function automatic answer_t trie_apply(op_t op, logic [31:0] key);
        answer_t a;
        node_t n, nx, par;
        int need, avail;
        logic want, b;
        a = '0;
        n = '0;
        case (op)
            OP_INSERT:
            begin
                need = 0;
                for (int d = 0; d < KEY_BITS; d++) begin
                    nx = kid_get(n, key[31-d]);
                    if (nx == 0) begin
                        need = KEY_BITS - d;
                        break;
                    end
                    n = nx;
                end
                if (need != 0) begin
                    avail = spare_cnt + ((next_unused < NODE_COUNT) ? NODE_COUNT - next_unused : 0);
                    if (avail < need) a.status = ST_FULL;
                    else
                        for (int d = KEY_BITS - need; d < KEY_BITS; d++) begin
                            nx = grab_node();
                            kid_set(n, key[31-d], nx);
                            n = nx;
                        end
                end
            end
            OP_ERASE:
            begin
                for (int d = 0; d < KEY_BITS; d++) begin
                    nx = kid_get(n, key[31-d]);
                    if (nx == 0) return a;
                    walk_nodes[d] = nx;
                    n = nx;
                end
                for (int d = KEY_BITS - 1; d >= 0; d--) begin
                    par = (d > 0) ? walk_nodes[d-1] : '0;
                    if (spare_cnt < NODE_COUNT) begin
                        spare_nodes[spare_cnt] = walk_nodes[d];
                        spare_cnt++;
                    end
                    kid_set(par, key[31-d], '0);
                    if (d == 0 || kid_get(par, 0) != 0 || kid_get(par, 1) != 0) break;
                end
            end
            OP_QUERY:
            begin
                if (top_kids[0] == 0 && top_kids[1] == 0) a.status = ST_EMPTY;
                else
                    for (int d = 0; d < KEY_BITS; d++) begin
                        want = ~key[31-d];
                        b = (kid_get(n, want) != 0) ? want : ~want;
                        a.best_key = {a.best_key[30:0], b};
                        n = kid_get(n, b);
                        if (n == 0) break;
                    end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        err_count++;
    endtask

    function automatic int short_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
    endfunction

    task automatic send_item(op_t op, logic [31:0] key, logic typed, answer_t typed_ans);
        answer_t a;
        a = trie_apply(op, key);
        if (typed && a !== typed_ans)
            report_mismatch("table row", {30'd0, a.status}, {30'd0, typed_ans.status});
        pending_answers.push_back(typed ? typed_ans : a);
        pending_typed.push_back(typed);
        s_tdata <= key;
        s_tuser <= op;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_answers.size() != 0) @(negedge clk);
    endtask

    // result checker and watchdog
    always @(posedge clk) begin
        answer_t got, want;
        if (s_tvalid && s_tready || m_tvalid && m_tready) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > 20000) begin
            $display("tb_top failed");
            $finish;
        end
        if (m_tvalid && m_tready) begin
            got.best_key = m_tdata;
            got.status   = m_tuser;
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result", got.best_key, '0);
            end
            else begin
                want = pending_answers.pop_front();
                void'(pending_typed.pop_front());
                if (got.best_key !== want.best_key)
                    report_mismatch("best_key", got.best_key, want.best_key);
                if (got.status !== want.status)
                    report_mismatch("status", {30'd0, got.status}, {30'd0, want.status});
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int g;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (900) @(negedge clk);
                hold_sink = 0;
            end
            g = ($urandom_range(0, 3) == 0) ? short_gap() : 0;
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
            else m_tready <= 1'b1;
        end
    end

    function automatic logic [31:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(0, 2) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)] ^
                   (($urandom_range(0, 1)) ? 32'd0 : (32'd1 << $urandom_range(0, 31)));
        return $urandom();
    endfunction

    initial begin
        row_t tbl [$];
        row_t r;
        op_t op;
        logic [31:0] k;
        int g;
        top_kids[0] = '0;
        top_kids[1] = '0;
        spare_cnt = 0;
        next_unused = 1;
        for (int i = 0; i < NODE_COUNT; i++) begin
            trie_kids[i][0] = '0;
            trie_kids[i][1] = '0;
        end
        // directed table; typed answers only where obvious
        tbl.push_back('{OP_QUERY,  32'h0,        1'b1, '{32'h0, ST_EMPTY}});
        tbl.push_back('{OP_ERASE,  32'h1234,     1'b1, '{32'h0, ST_DONE}});
        tbl.push_back('{OP_NONE,   32'hFFFFFFFF, 1'b1, '{32'h0, ST_DONE}});
        tbl.push_back('{OP_INSERT, 32'h0,        1'b1, '{32'h0, ST_DONE}});
        tbl.push_back('{OP_QUERY,  32'hFFFFFFFF, 1'b1, '{32'h0, ST_DONE}});
        tbl.push_back('{OP_INSERT, 32'h0,        1'b1, '{32'h0, ST_DONE}});
        tbl.push_back('{OP_INSERT, 32'hFFFFFFFF, 1'b1, '{32'h0, ST_DONE}});
        tbl.push_back('{OP_QUERY,  32'h0,        1'b1, '{32'hFFFFFFFF, ST_DONE}});
        tbl.push_back('{OP_QUERY,  32'hFFFFFFFF, 1'b1, '{32'h0, ST_DONE}});
        tbl.push_back('{OP_INSERT, 32'h80000000, 1'b0, '{32'h0, ST_DONE}});
        tbl.push_back('{OP_INSERT, 32'h7FFFFFFF, 1'b0, '{32'h0, ST_DONE}});
        tbl.push_back('{OP_QUERY,  32'h00000001, 1'b0, '{32'h0, ST_DONE}});
        tbl.push_back('{OP_QUERY,  32'hAAAAAAAA, 1'b0, '{32'h0, ST_DONE}});
        tbl.push_back('{OP_ERASE,  32'hFFFFFFFF, 1'b0, '{32'h0, ST_DONE}});
        tbl.push_back('{OP_ERASE,  32'hFFFFFFFF, 1'b0, '{32'h0, ST_DONE}});
        tbl.push_back('{OP_QUERY,  32'h0,        1'b0, '{32'h0, ST_DONE}});
        tbl.push_back('{OP_ERASE,  32'h0,        1'b0, '{32'h0, ST_DONE}});
        tbl.push_back('{OP_ERASE,  32'h80000000, 1'b0, '{32'h0, ST_DONE}});
        tbl.push_back('{OP_ERASE,  32'h7FFFFFFF, 1'b0, '{32'h0, ST_DONE}});
        tbl.push_back('{OP_QUERY,  32'h55555555, 1'b1, '{32'h0, ST_EMPTY}});
        tbl.push_back('{OP_NONE,   32'h0,        1'b1, '{32'h0, ST_DONE}});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (tbl[i]) begin
            r = tbl[i];
            send_item(r.op, r.key, r.has_exp, r.exp);
            g = short_gap();
            if (g > 0) begin
                s_tvalid <= 1'b0;
                repeat (g) @(negedge clk);
            end
        end
        wait_drained();

        // random phase; pool-full occurs once many distinct keys are stored
        for (int i = 0; i < 1650; i++) begin
            if (i == 300) hold_sink = 1;
            if (i == 900) wait_drained();
            g = $urandom_range(0, 99);
            if (i > 1000 && i < 1400) op = (g < 70) ? OP_INSERT : (g < 85) ? OP_QUERY : OP_ERASE;
            else op = (g < 40) ? OP_INSERT : (g < 65) ? OP_ERASE : (g < 97) ? OP_QUERY : OP_NONE;
            k = (op == OP_INSERT && $urandom_range(0, 3) != 0) ? $urandom() : pick_key();
            if (op == OP_INSERT) key_pool.push_back(k);
            send_item(op, k, 1'b0, '0);
            g = ($urandom_range(0, 2) == 0) ? short_gap() : 0;
            if (g > 0) begin
                s_tvalid <= 1'b0;
                repeat (g) @(negedge clk);
            end
        end
        wait_drained();
        repeat (300) @(negedge clk);
        if (err_count == 0 && pending_answers.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
